/* design/llc_pkg.sv */
// Package for the LRU lookup cache: sizes, item types and controller commands.
// Used by every module of the block; depends on nothing.
package llc_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int KEY_BITS    = 64;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] data_out;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } ctrl_cmd_t;

endpackage

/* design/llc_ctrl.sv */
// Controller of the LRU lookup cache: sequences load, compare and update.
// Depends on llc_pkg; drives the datapath through ctrl_cmd_t.
module llc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_strobe,
  output llc_pkg::ctrl_cmd_t ctrl_cmd
);
  import llc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = (state_r == ST_UPD);
  assign ctrl_cmd.load    = start && (state_r == ST_IDLE);
  assign ctrl_cmd.compare = (state_r == ST_CMP);
  assign ctrl_cmd.update  = (state_r == ST_UPD);

endmodule

/* design/llc_dpath.sv */
// Datapath of the LRU lookup cache: entry storage, key compare, recency ranks.
// Depends on llc_pkg; driven by llc_ctrl through ctrl_cmd_t.
module llc_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  llc_pkg::ctrl_cmd_t           ctrl_cmd,
  input  llc_pkg::in_item_t            in_item,
  input  logic [llc_pkg::CAP_W-1:0]    capacity,
  output llc_pkg::out_item_t           out_item
);
  import llc_pkg::*;

  logic                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  logic [KEY_BITS-1:0]   keys_r  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] vals_r  [MAX_ENTRIES];
  logic                  valid_r [MAX_ENTRIES];
  logic [IDX_W-1:0]      rank_r  [MAX_ENTRIES];

  logic                  found_r;
  logic [IDX_W-1:0]      tgt_r;
  logic [CNT_W-1:0]      old_rank_r;
  out_item_t             out_r;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cap_eff;
  logic                  found;
  logic [IDX_W-1:0]      match_idx;
  logic [IDX_W-1:0]      victim_idx;
  logic [IDX_W-1:0]      free_idx;
  logic                  full;
  logic [IDX_W-1:0]      tgt_nxt;
  logic [CNT_W-1:0]      old_rank_nxt;
  out_item_t             out_nxt;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > MAX_ENTRIES) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  always_comb begin
    count      = '0;
    found      = 1'b0;
    match_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      count = count + CNT_W'(valid_r[i]);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && keys_r[i] == key_r) begin
        found     = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (valid_r[i] && CNT_W'(rank_r[i]) == count - CNT_W'(1)) begin
        victim_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    full = (count >= cap_eff);
  end

  always_comb begin
    out_nxt.hit = found;
    if (cmd_r == CMD_INSERT) begin
      out_nxt.data_out = val_r;
    end else if (found) begin
      out_nxt.data_out = vals_r[match_idx];
    end else begin
      out_nxt.data_out = '0;
    end
    if (found) begin
      tgt_nxt      = match_idx;
      old_rank_nxt = CNT_W'(rank_r[match_idx]);
    end else if (full) begin
      tgt_nxt      = victim_idx;
      old_rank_nxt = count - CNT_W'(1);
    end else begin
      tgt_nxt      = free_idx;
      old_rank_nxt = count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      cmd_r <= in_item.cmd;
      key_r <= in_item.key;
      val_r <= in_item.value;
    end
    if (ctrl_cmd.compare) begin
      tgt_r      <= tgt_nxt;
      old_rank_r <= old_rank_nxt;
      out_r      <= out_nxt;
    end
    if (ctrl_cmd.update && cmd_r == CMD_INSERT) begin
      vals_r[tgt_r] <= val_r;
      if (!found_r) begin
        keys_r[tgt_r] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      if (ctrl_cmd.compare) begin
        found_r <= found;
      end
      if (ctrl_cmd.update && (found_r || cmd_r == CMD_INSERT)) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (IDX_W'(i) == tgt_r) begin
            rank_r[i]  <= '0;
            valid_r[i] <= 1'b1;
          end else if (valid_r[i] && CNT_W'(rank_r[i]) < old_rank_r) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  assign out_item = out_r;

endmodule

/* design/lru_lookup_cache_top.sv */
// Top level of the fully associative LRU lookup cache with its capacity register.
// Depends on llc_pkg, llc_ctrl and llc_dpath.
//
//   channel | ports                                  | transfer when
//   --------+----------------------------------------+------------------------------
//   input   | start, busy, in_item                   | start high while busy is low
//   result  | out_strobe, out_item                   | every cycle out_strobe is high
//   config  | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite and
//           | prdata, pready                         | pready high
//
// Each item has three steps: a load, a parallel key compare over all entries,
// and an update that writes the entry and ranks while the result is strobed.
// busy stays high from the transfer until the result strobe, so a new item
// waits until the last is through. The result receiver cannot stall the block.
// Synchronous reset clears all entries and sets the capacity to three.
module lru_lookup_cache_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  llc_pkg::in_item_t             in_item,
  output logic                          out_strobe,
  output llc_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [llc_pkg::PADDR_W-1:0]   paddr,
  input  logic [llc_pkg::PDATA_W-1:0]   pwdata,
  output logic [llc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import llc_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  ctrl_cmd_t        ctrl_cmd;
  logic             reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (reg_wr && paddr[2] == REG_CAPACITY) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = PDATA_W'(capacity_r);
    end else begin
      prdata = '0;
    end
  end

  llc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .ctrl_cmd   (ctrl_cmd)
  );

  llc_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_cmd (ctrl_cmd),
    .in_item  (in_item),
    .capacity (capacity_r),
    .out_item (out_item)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for lru_lookup_cache_top: directed and random lookups and inserts
// under several capacities, checked against a scoreboard that tracks keys, values and ranks.
// Depends on llc_pkg and lru_lookup_cache_top.
`timescale 1ns / 1ps

module testbench;
  import llc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  class lru_shadow;
    logic [KEY_BITS-1:0]   keys [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] vals [MAX_ENTRIES];
    bit                    valid [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank [MAX_ENTRIES];
    logic [CAP_W-1:0]      capacity;
    out_item_t             pending_replies [$];
    int                    mismatches;

    function new();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        keys[i] = '0;
        vals[i] = '0;
        valid[i] = 1'b0;
        rank[i] = '0;
      end
      capacity = CAP_RESET;
      mismatches = 0;
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    function void make_newest(int idx, logic [IDX_W-1:0] old_rank);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (i != idx && valid[i] && rank[i] < old_rank) rank[i] = rank[i] + IDX_W'(1);
      end
      rank[idx] = '0;
    endfunction

    function void accept_request(in_item_t req);
      int found;
      int held;
      int cap;
      int victim;
      int slot;
      logic [IDX_W-1:0] oldest;
      bit any;
      out_item_t reply;
      found = -1;
      held = 0;
      cap = capacity;
      if (cap < 1) cap = 1;
      if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid[i]) begin
          held++;
          if (found < 0 && keys[i] == req.key) found = i;
        end
      end
      if (req.cmd == CMD_LOOKUP) begin
        if (found >= 0) begin
          reply.hit = 1'b1;
          reply.data_out = vals[found];
          make_newest(found, rank[found]);
        end else begin
          reply.hit = 1'b0;
          reply.data_out = '0;
        end
      end else begin
        reply.hit = (found >= 0);
        reply.data_out = req.value;
        if (found >= 0) begin
          vals[found] = req.value;
          make_newest(found, rank[found]);
        end else if (held >= cap) begin
          victim = 0;
          oldest = '0;
          any = 1'b0;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid[i] && (!any || rank[i] > oldest)) begin
              victim = i;
              oldest = rank[i];
              any = 1'b1;
            end
          end
          keys[victim] = req.key;
          vals[victim] = req.value;
          make_newest(victim, oldest);
        end else begin
          slot = 0;
          for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid[i]) slot = i;
          end
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid[i]) rank[i] = rank[i] + IDX_W'(1);
          end
          valid[slot] = 1'b1;
          keys[slot] = req.key;
          vals[slot] = req.value;
          rank[slot] = '0;
        end
      end
      pending_replies = {pending_replies, reply};
    endfunction

    task check_response(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result hit=%0b data=%h", got.hit, got.data_out));
        return;
      end
      want = pending_replies.pop_front();
      if (got.hit !== want.hit)
        flag_mismatch($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.data_out !== want.data_out)
        flag_mismatch($sformatf("data_out got %h want %h", got.data_out, want.data_out));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  lru_shadow            shadow;
  bit                   idle_ok = 1'b1;
  int                   quiet_cycles = 0;

  lru_lookup_cache_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) shadow.check_response(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic c, input logic [KEY_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v);
    in_item_t req;
    req.cmd = c;
    req.key = k;
    req.value = v;
    if (idle_ok && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    shadow.accept_request(req);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= {28'($urandom()), cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow.capacity = cap;
  endtask

  initial begin
    logic [KEY_BITS-1:0] pool [16];
    logic [KEY_BITS-1:0] k;
    logic [CAP_W-1:0]    cap;
    int                  psize;
    int                  r;
    shadow = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset capacity of three: extremes, update, fill and eviction.
    send_item(CMD_LOOKUP, '0, '1);
    send_item(CMD_INSERT, '0, '1);
    send_item(CMD_INSERT, '1, '0);
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_LOOKUP, '1, '1);
    send_item(CMD_INSERT, '0, 32'h1234_5678);
    send_item(CMD_INSERT, 64'h5555_aaaa_5555_aaaa, 32'haaaa_5555);
    send_item(CMD_INSERT, 64'haaaa_5555_aaaa_5555, 32'h5555_aaaa);
    send_item(CMD_LOOKUP, '1, '0);
    send_item(CMD_LOOKUP, '0, '0);
    // Capacity lowered below the held entries, then zero, then above the maximum.
    settle();
    write_capacity(4'd1);
    send_item(CMD_INSERT, 64'h0123_4567_89ab_cdef, 32'hdead_beef);
    send_item(CMD_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
    send_item(CMD_LOOKUP, '0, '0);
    settle();
    write_capacity(4'd0);
    send_item(CMD_INSERT, 64'hfedc_ba98_7654_3210, 32'h0000_0001);
    send_item(CMD_LOOKUP, 64'hfedc_ba98_7654_3210, '0);
    settle();
    write_capacity(4'd15);
    send_item(CMD_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001);
    send_item(CMD_LOOKUP, 64'h8000_0000_0000_0001, '0);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: cap = 4'd15;
        1: cap = 4'd8;
        2: cap = 4'd1;
        3: cap = 4'd0;
        4: cap = 4'd2;
        default: cap = CAP_W'($urandom_range(0, 15));
      endcase
      write_capacity(cap);
      idle_ok = (ph != 5);
      psize = (cap < 1) ? 1 : (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap;
      psize = psize + 4;
      for (int i = 0; i < 16; i++) pool[i] = {$urandom(), $urandom()};
      for (int n = 0; n < 105; n++) begin
        r = $urandom_range(0, 99);
        k = pool[$urandom_range(0, psize - 1)];
        if (r >= 80 && r < 90) k = k ^ (64'd1 << $urandom_range(0, KEY_BITS - 1));
        else if (r >= 90) k = {$urandom(), $urandom()};
        send_item(1'($urandom_range(0, 1)), k, $urandom());
      end
    end
    idle_ok = 1'b1;

    settle();
    repeat (10) @(posedge clk);
    while (shadow.pending_replies.size() != 0) begin
      void'(shadow.pending_replies.pop_front());
      shadow.flag_mismatch("expected result never arrived");
    end
    if (shadow.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
